// ----- src/serl_pkg.sv -----
// serl_pkg: shared types, codes and stream field widths for the event ring log
// no dependencies; used by sequenced_event_ring_log

package serl_pkg;

    localparam int CAPACITY_DEF = 32;

    localparam int CMD_W   = 2;
    localparam int TIME_W  = 64;
    localparam int TYPE_W  = 8;
    localparam int SRC_W   = 8;
    localparam int VALUE_W = 32;
    localparam int IDX_W   = 8;
    localparam int SEQ_W   = 32;

    localparam int S_TDATA_W = 128;
    localparam int M_TDATA_W = 152;

    typedef enum logic [CMD_W-1:0] {
        CMD_APPEND = 2'd0,
        CMD_READ   = 2'd1,
        CMD_CLEAR  = 2'd2
    } cmd_t;

    localparam logic STATUS_OK        = 1'b0;
    localparam logic STATUS_NOT_FOUND = 1'b1;

    typedef struct packed {
        logic [SEQ_W-1:0]   seq;
        logic [TIME_W-1:0]  ev_time;
        logic [TYPE_W-1:0]  ev_type;
        logic [SRC_W-1:0]   ev_source;
        logic [VALUE_W-1:0] ev_value;
    } entry_t;

endpackage

// ----- src/sequenced_event_ring_log.sv -----
// sequenced_event_ring_log: circular event log with sequence numbering
// pipeline: an accepted item is registered in the first stage, then in the result stage
// one item per cycle unless stalled; append writes memory, read does a registered read
// reset: synchronous active-low aresetn clears pointers, count, sequence and valids
// entry memory is not cleared; entries are only read below the stored count
// depends on serl_pkg

module sequenced_event_ring_log #(
    parameter int CAPACITY = serl_pkg::CAPACITY_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // command, event_time, event_type, event_source, event_value, newest_index, pad
    input  logic [serl_pkg::S_TDATA_W-1:0]  s_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // status, seq_number, out_time, out_type, out_source, out_value, pad
    output logic [serl_pkg::M_TDATA_W-1:0]  m_tdata
);

    localparam int SLOT_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W  = $clog2(CAPACITY + 1);

    // input field unpacking
    logic [serl_pkg::CMD_W-1:0]   in_cmd;
    logic [serl_pkg::TIME_W-1:0]  in_time;
    logic [serl_pkg::TYPE_W-1:0]  in_type;
    logic [serl_pkg::SRC_W-1:0]   in_source;
    logic [serl_pkg::VALUE_W-1:0] in_value;
    logic [serl_pkg::IDX_W-1:0]   in_idx;

    assign in_cmd    = s_tdata[1:0];
    assign in_time   = s_tdata[65:2];
    assign in_type   = s_tdata[73:66];
    assign in_source = s_tdata[81:74];
    assign in_value  = s_tdata[113:82];
    assign in_idx    = s_tdata[121:114];

    // log state
    logic [SLOT_W-1:0]          write_slot_reg, write_slot_next;
    logic [CNT_W-1:0]           count_reg, count_next;
    logic [serl_pkg::SEQ_W-1:0] last_seq_reg, last_seq_next;

    // first stage
    logic                       s1_valid_reg;
    logic                       s1_status_reg;
    logic                       s1_hit_reg;
    logic [serl_pkg::SEQ_W-1:0] s1_seq_reg;
    serl_pkg::entry_t           rd_data_reg;

    // result stage
    logic                          m_valid_reg;
    logic [serl_pkg::M_TDATA_W-1:0] m_data_reg, m_data_next;

    serl_pkg::entry_t mem [CAPACITY];

    logic                       advance;
    logic                       s_accept;
    logic                       do_append;
    logic                       do_read;
    logic                       do_clear;
    logic                       read_hit;
    logic [serl_pkg::SEQ_W-1:0] new_seq;
    logic [SLOT_W-1:0]          newest_slot;
    logic [8:0]                 pos_wide;
    logic [SLOT_W-1:0]          rd_addr;
    serl_pkg::entry_t           wr_entry;

    assign advance  = !m_valid_reg || m_tready;
    assign s_tready = !s1_valid_reg || advance;
    assign s_accept = s_tvalid && s_tready;

    assign do_append = s_accept && (in_cmd == serl_pkg::CMD_APPEND);
    assign do_read   = s_accept && (in_cmd == serl_pkg::CMD_READ);
    assign do_clear  = s_accept && (in_cmd == serl_pkg::CMD_CLEAR);

    assign read_hit = 9'(in_idx) < 9'(count_reg);
    assign new_seq  = (count_reg != '0) ? last_seq_reg + serl_pkg::SEQ_W'(1)
                                        : serl_pkg::SEQ_W'(1);

    // newest entry sits one slot behind the write pointer
    assign newest_slot = (write_slot_reg == '0) ? SLOT_W'(CAPACITY - 1)
                                                : write_slot_reg - SLOT_W'(1);
    assign pos_wide = 9'(newest_slot) - 9'(in_idx)
                    + ((9'(in_idx) > 9'(newest_slot)) ? 9'(CAPACITY) : 9'd0);
    assign rd_addr  = read_hit ? SLOT_W'(pos_wide) : '0;

    always_comb begin
        wr_entry.seq       = new_seq;
        wr_entry.ev_time   = in_time;
        wr_entry.ev_type   = in_type;
        wr_entry.ev_source = in_source;
        wr_entry.ev_value  = in_value;
    end

    always_comb begin
        write_slot_next = write_slot_reg;
        count_next      = count_reg;
        last_seq_next   = last_seq_reg;
        if (do_append) begin
            write_slot_next = (write_slot_reg == SLOT_W'(CAPACITY - 1))
                            ? '0 : write_slot_reg + SLOT_W'(1);
            if (count_reg != CNT_W'(CAPACITY)) begin
                count_next = count_reg + CNT_W'(1);
            end
            last_seq_next = new_seq;
        end else if (do_clear) begin
            write_slot_next = '0;
            count_next      = '0;
            last_seq_next   = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            write_slot_reg <= '0;
            count_reg      <= '0;
            last_seq_reg   <= '0;
        end else begin
            write_slot_reg <= write_slot_next;
            count_reg      <= count_next;
            last_seq_reg   <= last_seq_next;
        end
    end

    // entry memory, at most one write or one read per item
    always_ff @(posedge aclk) begin
        if (do_append) begin
            mem[write_slot_reg] <= wr_entry;
        end
        if (do_read && read_hit) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (s_tready) begin
            s1_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            s1_status_reg <= (do_read && !read_hit) ? serl_pkg::STATUS_NOT_FOUND
                                                    : serl_pkg::STATUS_OK;
            s1_hit_reg    <= do_read && read_hit;
            s1_seq_reg    <= do_append ? new_seq : '0;
        end
    end

    always_comb begin
        m_data_next = '0;
        m_data_next[0] = s1_status_reg;
        if (s1_hit_reg) begin
            m_data_next[32:1]    = rd_data_reg.seq;
            m_data_next[96:33]   = rd_data_reg.ev_time;
            m_data_next[104:97]  = rd_data_reg.ev_type;
            m_data_next[112:105] = rd_data_reg.ev_source;
            m_data_next[144:113] = rd_data_reg.ev_value;
        end else begin
            m_data_next[32:1] = s1_seq_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            m_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && s1_valid_reg) begin
            m_data_reg <= m_data_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        9'(count_reg) <= 9'(CAPACITY))
        else $error("stored count above capacity");

    a_slot_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        9'(write_slot_reg) < 9'(CAPACITY))
        else $error("write slot out of range");

    a_seq_step: assert property (@(posedge aclk) disable iff (!aresetn)
        do_append && (count_reg != '0) |=> last_seq_reg == $past(last_seq_reg) + 32'd1)
        else $error("sequence did not advance by one");

    a_not_found_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[0] == serl_pkg::STATUS_NOT_FOUND) |-> m_tdata[144:1] == '0)
        else $error("not-found result carries nonzero payload");
`endif

endmodule

// ----- sim/testbench.sv -----
// testbench: self-checking regression for sequenced_event_ring_log over its stream ports
// drives append, read and clear items with random gaps and stalls, predicts each reply
// depends on serl_pkg and sequenced_event_ring_log

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import serl_pkg::*;

    localparam int CAP = CAPACITY_DEF;
    localparam int IDLE_LIMIT = 2000;
    localparam int RANDOM_ITEMS = 1525;

    typedef struct packed {
        cmd_t                command;
        logic signed [63:0]  ev_time;
        logic [7:0]          ev_type;
        logic [7:0]          ev_source;
        logic signed [31:0]  ev_value;
        logic [7:0]          newest_index;
    } log_cmd_t;

    typedef struct packed {
        logic                status;
        logic [31:0]         seq_number;
        logic signed [63:0]  out_time;
        logic [7:0]          out_type;
        logic [7:0]          out_source;
        logic signed [31:0]  out_value;
    } log_reply_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;

    log_cmd_t    cmd_queue[$];
    log_reply_t  predicted_replies[$];
    log_cmd_t    cmd_in_flight;
    int          error_count = 0;
    int          idle_cycles = 0;
    int          send_gap = 0;
    int          sink_stall = 0;
    bit          send_burst = 1'b0;
    bit          sink_burst = 1'b0;

    entry_t      log_entries[CAP];
    int unsigned log_write_slot = 0;
    int unsigned log_count = 0;
    logic [31:0] log_last_seq = '0;

    sequenced_event_ring_log u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    function automatic log_reply_t ring_log_apply(log_cmd_t c);
        log_reply_t  r;
        logic [31:0] seq;
        int unsigned newest;
        int unsigned pos;
        r = '0;
        case (c.command)
            CMD_APPEND: begin
                seq = (log_count > 0) ? log_last_seq + 32'd1 : 32'd1;
                log_entries[log_write_slot] = '{seq, c.ev_time, c.ev_type, c.ev_source,
                                                c.ev_value};
                log_write_slot = (log_write_slot + 1) % CAP;
                if (log_count < CAP) begin
                    log_count++;
                end
                log_last_seq = seq;
                r.seq_number = seq;
            end
            CMD_READ: begin
                if (c.newest_index >= log_count) begin
                    r.status = STATUS_NOT_FOUND;
                end else begin
                    newest = (log_write_slot + CAP - 1) % CAP;
                    pos = (newest + CAP - c.newest_index) % CAP;
                    r.status = STATUS_OK;
                    r.seq_number = log_entries[pos].seq;
                    r.out_time = log_entries[pos].ev_time;
                    r.out_type = log_entries[pos].ev_type;
                    r.out_source = log_entries[pos].ev_source;
                    r.out_value = log_entries[pos].ev_value;
                end
            end
            CMD_CLEAR: begin
                log_write_slot = 0;
                log_count = 0;
                log_last_seq = '0;
            end
            default: begin
            end
        endcase
        return r;
    endfunction

    task automatic push_append(logic [63:0] t, logic [7:0] ty, logic [7:0] src,
                               logic [31:0] v);
        log_cmd_t c;
        c = '0;
        c.command = CMD_APPEND;
        c.ev_time = t;
        c.ev_type = ty;
        c.ev_source = src;
        c.ev_value = v;
        c.newest_index = 8'($urandom);
        cmd_queue.push_back(c);
    endtask

    task automatic push_read(logic [7:0] idx);
        log_cmd_t c;
        c = '0;
        c.command = CMD_READ;
        c.ev_time = {$urandom, $urandom};
        c.newest_index = idx;
        cmd_queue.push_back(c);
    endtask

    task automatic push_clear();
        log_cmd_t c;
        c = '0;
        c.command = CMD_CLEAR;
        c.newest_index = 8'($urandom);
        cmd_queue.push_back(c);
    endtask

    // item source
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            send_gap = $urandom_range(0, 8);
        end else begin
            if (s_tvalid && s_tready) begin
                predicted_replies.push_back(ring_log_apply(cmd_in_flight));
            end
            if (!s_tvalid || s_tready) begin
                if (send_gap > 0) begin
                    s_tvalid <= 1'b0;
                    send_gap--;
                end else if (cmd_queue.size() > 0) begin
                    cmd_in_flight = cmd_queue.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata <= {6'b0, cmd_in_flight.newest_index, cmd_in_flight.ev_value,
                                cmd_in_flight.ev_source, cmd_in_flight.ev_type,
                                cmd_in_flight.ev_time, cmd_in_flight.command};
                    if ($urandom_range(0, 47) == 0) begin
                        send_burst = !send_burst;
                    end
                    send_gap = send_burst ? 0 : $urandom_range(0, 8);
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // reply sink and checker
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            sink_stall = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (predicted_replies.size() == 0) begin
                    $error("unexpected reply item: m_tdata %h", m_tdata);
                    error_count++;
                end else begin
                    log_reply_t exp_r;
                    log_reply_t got_r;
                    exp_r = predicted_replies.pop_front();
                    got_r.status = m_tdata[0];
                    got_r.seq_number = m_tdata[32:1];
                    got_r.out_time = m_tdata[96:33];
                    got_r.out_type = m_tdata[104:97];
                    got_r.out_source = m_tdata[112:105];
                    got_r.out_value = m_tdata[144:113];
                    if (got_r.status !== exp_r.status) begin
                        $error("status: expected %0d, actual %0d", exp_r.status, got_r.status);
                        error_count++;
                    end
                    if (got_r.seq_number !== exp_r.seq_number) begin
                        $error("seq_number: expected %0d, actual %0d", exp_r.seq_number,
                               got_r.seq_number);
                        error_count++;
                    end
                    if (got_r.out_time !== exp_r.out_time) begin
                        $error("out_time: expected %0d, actual %0d", exp_r.out_time,
                               got_r.out_time);
                        error_count++;
                    end
                    if (got_r.out_type !== exp_r.out_type) begin
                        $error("out_type: expected %0d, actual %0d", exp_r.out_type,
                               got_r.out_type);
                        error_count++;
                    end
                    if (got_r.out_source !== exp_r.out_source) begin
                        $error("out_source: expected %0d, actual %0d", exp_r.out_source,
                               got_r.out_source);
                        error_count++;
                    end
                    if (got_r.out_value !== exp_r.out_value) begin
                        $error("out_value: expected %0d, actual %0d", exp_r.out_value,
                               got_r.out_value);
                        error_count++;
                    end
                end
                if ($urandom_range(0, 47) == 0) begin
                    sink_burst = !sink_burst;
                end
                sink_stall = sink_burst ? 0 : $urandom_range(0, 8);
            end
            if (sink_stall > 0) begin
                m_tready <= 1'b0;
                sink_stall--;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // watchdog on cycles with no item moving
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("sequenced_event_ring_log regression: fail");
                $finish;
            end
        end
    end

    initial begin
        int roll;
        int run_len;

        // empty log, field extremes, wrap of slots left to the random part
        push_read(8'd0);
        push_read(8'd255);
        push_append(64'h8000_0000_0000_0000, 8'd0, 8'd0, 32'h8000_0000);
        push_append(64'h7FFF_FFFF_FFFF_FFFF, 8'd255, 8'd255, 32'h7FFF_FFFF);
        push_append(64'd0, 8'hA5, 8'h5A, 32'd0);
        push_append(64'hFFFF_FFFF_FFFF_FFFF, 8'h5A, 8'hA5, 32'hFFFF_FFFF);
        push_read(8'd0);
        push_read(8'd1);
        push_read(8'd2);
        push_read(8'd3);
        push_read(8'd4);
        push_read(8'd255);
        push_clear();
        push_read(8'd0);
        push_clear();
        push_append(64'h0123_4567_89AB_CDEF, 8'd1, 8'd2, 32'd3);
        push_read(8'd0);
        push_read(8'd1);
        push_append({$urandom, $urandom}, 8'($urandom), 8'($urandom), $urandom);
        push_read(8'd1);
        push_read(8'd0);

        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            roll = $urandom_range(0, 199);
            if (roll < 3) begin
                push_clear();
            end else if (roll < 12) begin
                // run of appends that can push the log past capacity
                run_len = $urandom_range(4, 40);
                for (int k = 0; k < run_len && i < RANDOM_ITEMS; k++, i++) begin
                    push_append({$urandom, $urandom}, 8'($urandom), 8'($urandom), $urandom);
                end
            end else if (roll < 100) begin
                push_append({$urandom, $urandom}, 8'($urandom), 8'($urandom), $urandom);
            end else begin
                roll = $urandom_range(0, 9);
                if (roll < 6) begin
                    push_read(8'($urandom_range(0, CAP - 1)));
                end else if (roll < 8) begin
                    push_read(8'($urandom_range(0, CAP + 8)));
                end else begin
                    push_read(8'($urandom_range(0, 255)));
                end
            end
        end

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        while (cmd_queue.size() > 0 || s_tvalid) begin
            @(posedge aclk);
        end
        while (predicted_replies.size() > 0) begin
            @(posedge aclk);
        end
        repeat (10) @(posedge aclk);

        if (error_count == 0) begin
            $display("sequenced_event_ring_log regression: pass");
        end else begin
            $display("sequenced_event_ring_log regression: fail");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
src/serl_pkg.sv
src/sequenced_event_ring_log.sv
sim/testbench.sv
